FILE: rtl/cbsim_pkg.sv
// Shared types and constants for the cartridge bank-switch and IRQ mapper.
`timescale 1ns / 1ps
package cbsim_pkg;

    localparam int PATTERN_SLOTS = 8;
    localparam int SLOT_W        = $clog2(PATTERN_SLOTS);

    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int LINE_W  = 9;
    localparam int BANK_W  = 8;
    localparam int LOG2_W  = 4;

    // Stream payload widths; the data widths are padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_PRG   = 2'd2,
        KIND_CHR   = 2'd3
    } kind_t;

    typedef enum logic {
        CFG_PRG_LOG2 = 1'b0,
        CFG_CHR_LOG2 = 1'b1
    } cfg_index_t;

    localparam logic [LOG2_W-1:0] PRG_LOG2_RESET = 4'd5;
    localparam logic [LOG2_W-1:0] CHR_LOG2_RESET = 4'd8;

    // Register decode
    localparam logic [ADDR_W-1:0] ADDR_PAT_FIRST = 16'hB000;
    localparam logic [ADDR_W-1:0] ADDR_PAT_LAST  = 16'hE003;
    localparam logic [3:0] PAGE_PRG_LOW    = 4'h8;
    localparam logic [3:0] PAGE_MIRROR     = 4'h9;
    localparam logic [3:0] PAGE_PRG_SECOND = 4'hA;
    localparam logic [3:0] PAGE_IRQ        = 4'hF;
    localparam logic [1:0] OFS_PRG_BANK = 2'd0;
    localparam logic [1:0] OFS_MIRROR   = 2'd0;
    localparam logic [1:0] OFS_SWAP     = 2'd1;
    localparam logic [1:0] OFS_CNT_LO   = 2'd0;
    localparam logic [1:0] OFS_CNT_HI   = 2'd2;
    // Subtracting 6 from address bits 13:11 is adding 2 modulo 8
    localparam logic [SLOT_W-1:0] PAT_SLOT_BIAS = 3'd2;

    // Program lookup windows, address bits 14:13
    localparam logic [1:0] WIN_LOW    = 2'd0;
    localparam logic [1:0] WIN_SECOND = 2'd1;
    localparam logic [1:0] WIN_HIGH   = 2'd2;

    localparam logic [BANK_W-1:0] BANK_SECOND_LAST = 8'hFE;
    localparam logic [BANK_W-1:0] BANK_LAST        = 8'hFF;
    localparam logic [BANK_W-1:0] PRG_SECOND_RESET = 8'h01;

    localparam logic [7:0]        IRQ_FIRE_COUNT = 8'd238;
    localparam logic [7:0]        IRQ_VISIBLE_ADJ = 8'd8;
    localparam logic [LINE_W-1:0] VISIBLE_LINES  = 9'd240;

    typedef struct packed {
        kind_t              kind;
        logic [ADDR_W-1:0]  address;
        logic [DATA_W-1:0]  data;
        logic [LINE_W-1:0]  scanline;
    } item_t;

    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic              mirror_horizontal;
        logic              irq_line;
    } result_t;

    function automatic logic [BANK_W-1:0] bank_mask(input logic [LOG2_W-1:0] lg);
        logic [BANK_W:0] full;
        full = (9'd1 << lg[2:0]) - 9'd1;
        if (lg[3])
            return BANK_LAST;
        return full[BANK_W-1:0];
    endfunction

endpackage

FILE: rtl/cbsim_core.sv
// Mapper register file, IRQ counter and bank lookup for one item.
`timescale 1ns / 1ps
module cbsim_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  cbsim_pkg::cfg_index_t             cfg_index,
    input  logic [cbsim_pkg::LOG2_W-1:0]      cfg_data,
    input  logic                              step,
    input  cbsim_pkg::item_t                  item,
    output cbsim_pkg::result_t                result
);
    import cbsim_pkg::*;

    logic [LOG2_W-1:0] prg_log2_reg;
    logic [LOG2_W-1:0] chr_log2_reg;

    logic              slot_swap_reg,       slot_swap_next;
    logic [BANK_W-1:0] prg_low_reg,         prg_low_next;
    logic [BANK_W-1:0] prg_second_reg,      prg_second_next;
    logic [BANK_W-1:0] prg_high_reg,        prg_high_next;
    logic [BANK_W-1:0] pat_reg  [PATTERN_SLOTS];
    logic [BANK_W-1:0] pat_next [PATTERN_SLOTS];
    logic              mirror_reg,          mirror_next;
    logic              irq_en_reg,          irq_en_next;
    logic [7:0]        irq_count_reg,       irq_count_next;
    logic              irq_pending_reg,     irq_pending_next;

    logic              pat_hit;
    logic [SLOT_W-1:0] pat_slot;
    logic [3:0]        page;
    logic [1:0]        low2;
    logic              place_en;
    logic [BANK_W-1:0] place_bank;
    logic [7:0]        count_inc;
    logic [BANK_W-1:0] raw_bank;
    logic [BANK_W-1:0] bank_val;

    assign page     = item.address[15:12];
    assign low2     = item.address[1:0];
    assign pat_hit  = (item.kind == KIND_WRITE) && (item.address >= ADDR_PAT_FIRST)
                      && (item.address <= ADDR_PAT_LAST);
    assign pat_slot = SLOT_W'(item.address[13:11] + PAT_SLOT_BIAS)
                      | {{(SLOT_W-1){1'b0}}, item.address[0]};
    assign count_inc = irq_count_reg + 8'd1;

    always_comb
    begin
        slot_swap_next   = slot_swap_reg;
        prg_low_next     = prg_low_reg;
        prg_second_next  = prg_second_reg;
        prg_high_next    = prg_high_reg;
        mirror_next      = mirror_reg;
        irq_en_next      = irq_en_reg;
        irq_count_next   = irq_count_reg;
        irq_pending_next = irq_pending_reg;
        place_en         = 1'b0;
        place_bank       = item.data;

        case (item.kind)
            KIND_WRITE:
            begin
                if (!pat_hit)
                begin
                    case (page)
                        PAGE_PRG_LOW:
                        begin
                            place_en = (low2 == OFS_PRG_BANK);
                        end
                        PAGE_MIRROR:
                        begin
                            if (low2 == OFS_MIRROR)
                                mirror_next = item.data[0];
                            else if (low2 == OFS_SWAP)
                            begin
                                // re-place whatever sits in the low slot now
                                slot_swap_next = item.data[1];
                                place_en       = 1'b1;
                                place_bank     = prg_low_reg;
                            end
                        end
                        PAGE_PRG_SECOND:
                        begin
                            if (low2 == OFS_PRG_BANK)
                                prg_second_next = item.data;
                        end
                        PAGE_IRQ:
                        begin
                            if (low2 == OFS_CNT_LO)
                                irq_count_next = {irq_count_reg[7:4], item.data[3:0]};
                            else if (low2 == OFS_CNT_HI)
                                irq_count_next = {item.data[3:0], irq_count_reg[3:0]};
                            else
                            begin
                                irq_en_next      = item.data[1];
                                irq_pending_next = 1'b0;
                                if (item.scanline < VISIBLE_LINES)
                                    irq_count_next = irq_count_reg - IRQ_VISIBLE_ADJ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            KIND_TICK:
            begin
                if (irq_en_reg)
                begin
                    irq_count_next = count_inc;
                    if (count_inc == IRQ_FIRE_COUNT)
                        irq_pending_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (place_en)
        begin
            if (slot_swap_next)
            begin
                prg_low_next  = BANK_SECOND_LAST;
                prg_high_next = place_bank;
            end
            else
            begin
                prg_low_next  = place_bank;
                prg_high_next = BANK_SECOND_LAST;
            end
        end
    end

    // Each pattern entry updates its own nibble
    always_comb
    begin
        for (int i = 0; i < PATTERN_SLOTS; i++)
        begin
            pat_next[i] = pat_reg[i];
            if (pat_hit && (pat_slot == SLOT_W'(i)))
            begin
                if (!item.address[1])
                    pat_next[i] = {pat_reg[i][7:4], item.data[3:0]};
                else
                    pat_next[i] = {item.data[3:0], pat_reg[i][3:0]};
            end
        end
    end

    always_comb
    begin
        case (item.address[14:13])
            WIN_LOW:    raw_bank = prg_low_reg;
            WIN_SECOND: raw_bank = prg_second_reg;
            WIN_HIGH:   raw_bank = prg_high_reg;
            default:    raw_bank = BANK_LAST;
        endcase
    end

    always_comb
    begin
        case (item.kind)
            KIND_PRG:
                bank_val = item.address[15] ? (raw_bank & bank_mask(prg_log2_reg)) : '0;
            KIND_CHR:
                bank_val = pat_reg[item.address[12:10]] & bank_mask(chr_log2_reg);
            default:
                bank_val = '0;
        endcase
    end

    assign result.bank              = bank_val;
    assign result.mirror_horizontal = mirror_next;
    assign result.irq_line          = irq_pending_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_log2_reg <= PRG_LOG2_RESET;
            chr_log2_reg <= CHR_LOG2_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PRG_LOG2: prg_log2_reg <= cfg_data;
                CFG_CHR_LOG2: chr_log2_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_swap_reg   <= 1'b0;
            prg_low_reg     <= '0;
            prg_second_reg  <= PRG_SECOND_RESET;
            prg_high_reg    <= BANK_SECOND_LAST;
            mirror_reg      <= 1'b0;
            irq_en_reg      <= 1'b0;
            irq_count_reg   <= '0;
            irq_pending_reg <= 1'b0;
            for (int i = 0; i < PATTERN_SLOTS; i++)
                pat_reg[i] <= BANK_W'(i);
        end
        else if (step)
        begin
            slot_swap_reg   <= slot_swap_next;
            prg_low_reg     <= prg_low_next;
            prg_second_reg  <= prg_second_next;
            prg_high_reg    <= prg_high_next;
            mirror_reg      <= mirror_next;
            irq_en_reg      <= irq_en_next;
            irq_count_reg   <= irq_count_next;
            irq_pending_reg <= irq_pending_next;
            for (int i = 0; i < PATTERN_SLOTS; i++)
                pat_reg[i] <= pat_next[i];
        end
    end

endmodule

FILE: rtl/cartridge_bank_switch_irq_mapper.sv
// Top level: stream ports, input register and result register around the mapper core.
`timescale 1ns / 1ps
// Cartridge bank-switch mapper with a scanline IRQ counter. Each item on the
// slave stream is a CPU register write, an IRQ tick, a program bank lookup or
// a pattern bank lookup, and produces exactly one result item (bank, mirroring,
// IRQ line). The block takes one item per clock when the output is drained;
// each item passes the input register, then the decode and lookup logic, then
// the result register. The user writes the bank-size registers through the cfg
// port only while no item is in flight; the block does not enforce this.
module cartridge_bank_switch_irq_mapper (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [cbsim_pkg::LOG2_W-1:0]        cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cbsim_pkg::S_TDATA_W-1:0]     s_tdata,  // address[15:0], data[23:16], scanline[32:24]
    input  logic [cbsim_pkg::S_TUSER_W-1:0]     s_tuser,  // kind[1:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cbsim_pkg::M_TDATA_W-1:0]     m_tdata   // bank[7:0], mirror_horizontal[8], irq_line[9]
);
    import cbsim_pkg::*;

    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t result_reg;
    result_t result;
    logic    advance;
    logic    fire;
    logic    s_accept;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    cbsim_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index_t'(cfg_index)),
        .cfg_data (cfg_data),
        .step     (fire),
        .item     (item_reg),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;

            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg.kind     <= kind_t'(s_tuser);
            item_reg.address  <= s_tdata[15:0];
            item_reg.data     <= s_tdata[23:16];
            item_reg.scanline <= s_tdata[32:24];
        end
        if (fire)
            result_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, result_reg.irq_line, result_reg.mirror_horizontal,
                       result_reg.bank};

endmodule

FILE: rtl/cbsim_checker.sv
// Port-level checker for the mapper, bound to the top level.
`timescale 1ns / 1ps
module cbsim_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // An accepted item is expected at the output once it has passed the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("accepted item did not reach the output");

    // An empty output stage never blocks the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Padding bits of the result stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:10] == 6'b000000))
        else $error("result padding not zero");

endmodule

bind cartridge_bank_switch_irq_mapper cbsim_checker u_checker (.*);
